// ----- rtl/imu_fd_pkg.sv -----
// Package: frame constants, kind codes and the type-to-kind decode for the IMU deframer
`default_nettype none

package imu_fd_pkg;

    localparam logic [7:0] HDR_BYTE      = 8'h55;
    localparam logic [7:0] TYPE_ACCEL    = 8'h51;
    localparam logic [7:0] TYPE_RATE     = 8'h52;
    localparam logic [7:0] TYPE_ANGLE    = 8'h53;
    localparam logic [7:0] TYPE_MAG      = 8'h54;
    localparam logic [7:0] TYPE_PORTS    = 8'h55;

    localparam int unsigned FRAME_LEN    = 11;
    localparam int unsigned SUM_LEN      = 10;
    localparam int unsigned POS_W        = 4;
    localparam int unsigned PAY_BYTES    = 8;
    localparam int unsigned PAY_IDX_W    = 3;

    localparam logic [POS_W-1:0] POS_HDR  = '0;
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY0 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CSUM = POS_W'(SUM_LEN);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(FRAME_LEN);

    typedef enum logic [2:0] {
        KIND_ACCEL   = 3'd0,
        KIND_RATE    = 3'd1,
        KIND_ANGLE   = 3'd2,
        KIND_MAG     = 3'd3,
        KIND_PORTS   = 3'd4,
        KIND_UNKNOWN = 3'd5
    } t_kind;

    function automatic t_kind type_to_kind(input logic [7:0] t);
        t_kind k;
        unique case (t)
            TYPE_ACCEL: k = KIND_ACCEL;
            TYPE_RATE:  k = KIND_RATE;
            TYPE_ANGLE: k = KIND_ANGLE;
            TYPE_MAG:   k = KIND_MAG;
            TYPE_PORTS: k = KIND_PORTS;
            default:    k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/imu_fd_if.sv -----
// Interfaces: byte input channel and frame result channel with valid/ready handshake
`default_nettype none

interface imu_fd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_fd_out_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  frame_type;
    logic        [2:0]  kind;
    logic signed [15:0] word0;
    logic signed [15:0] word1;
    logic signed [15:0] word2;
    logic signed [15:0] word3;
    logic               checksum_ok;

    modport source (
        output valid, output frame_type, output kind, output word0, output word1,
        output word2, output word3, output checksum_ok, input ready
    );
    modport sink (
        input valid, input frame_type, input kind, input word0, input word1,
        input word2, input word3, input checksum_ok, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/imu_frame_deframer.sv -----
// Top level: IMU byte-stream deframer with header resync and 8-bit sum checksum
`default_nettype none

// Takes one serial byte per cycle and parses 11-byte frames: header 0x55, type byte,
// four little-endian signed words and a checksum byte. Non-header bytes while waiting
// for a header are dropped. On each checksum byte one result is emitted, carrying the
// raw type, its kind code, the four words and a flag that the 8-bit sum of the first
// ten bytes matched; a failed checksum still emits a result. Throughput is one byte
// per cycle while the receiver holds no result: each byte passes an input register,
// a byte counter, an 8-bit adder and the result register. A result is registered on
// the edge at which its checksum byte leaves the input register, which waits while
// the receiver holds a result. The input accepts while the input register is empty,
// or while the result register is free or being drained in the same cycle; a result
// held by the receiver stalls the input once the input register is occupied.
module imu_frame_deframer
    import imu_fd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    imu_fd_in_if.sink         i_in,
    imu_fd_out_if.source      o_out
);

    logic                 r_in_vld;
    logic [7:0]           r_in_byte;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [7:0]           r_sum;
    logic [7:0]           n_sum;
    logic [7:0]           r_type;
    logic [7:0]           r_pay [PAY_BYTES];
    logic                 r_out_vld;
    logic [7:0]           r_frame_type;
    t_kind                r_kind;
    logic signed [15:0]   r_word [4];
    logic                 r_csum_ok;

    logic                 s_out_free;
    logic                 s_move;
    logic                 s_emit;
    logic                 s_wr_type;
    logic                 s_wr_pay;
    logic [PAY_IDX_W-1:0] s_pay_idx;
    logic [POS_W-1:0]     s_pos;

    assign s_out_free = !r_out_vld || o_out.ready;
    assign s_move     = r_in_vld && s_out_free;
    assign i_in.ready = !r_in_vld || s_out_free;

    assign s_pos     = (r_pos >= POS_END) ? POS_HDR : r_pos;
    assign s_pay_idx = PAY_IDX_W'(s_pos - POS_PAY0);

    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        s_emit    = 1'b0;
        s_wr_type = 1'b0;
        s_wr_pay  = 1'b0;
        if (s_move) begin
            priority if (s_pos == POS_HDR) begin
                if (r_in_byte == HDR_BYTE) begin
                    n_sum = r_in_byte;
                    n_pos = POS_TYPE;
                end else begin
                    n_sum = '0;
                    n_pos = POS_HDR;
                end
            end else if (s_pos < POS_CSUM) begin
                s_wr_type = (s_pos == POS_TYPE);
                s_wr_pay  = (s_pos != POS_TYPE);
                n_sum     = r_sum + r_in_byte;
                n_pos     = s_pos + POS_W'(1);
            end else begin
                s_emit = 1'b1;
                n_sum  = '0;
                n_pos  = POS_HDR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_pos     <= POS_HDR;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (s_move) begin
                r_in_vld <= 1'b0;
            end
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (s_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (s_wr_type) begin
            r_type <= r_in_byte;
        end
        if (s_wr_pay) begin
            r_pay[s_pay_idx] <= r_in_byte;
        end
        if (s_emit) begin
            r_frame_type <= r_type;
            r_kind       <= type_to_kind(r_type);
            r_word[0]    <= {r_pay[1], r_pay[0]};
            r_word[1]    <= {r_pay[3], r_pay[2]};
            r_word[2]    <= {r_pay[5], r_pay[4]};
            r_word[3]    <= {r_pay[7], r_pay[6]};
            r_csum_ok    <= (r_sum == r_in_byte);
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.frame_type  = r_frame_type;
    assign o_out.kind        = r_kind;
    assign o_out.word0       = r_word[0];
    assign o_out.word1       = r_word[1];
    assign o_out.word2       = r_word[2];
    assign o_out.word3       = r_word[3];
    assign o_out.checksum_ok = r_csum_ok;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CSUM)
        else $error("byte counter beyond checksum position");

    a_emit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_emit |=> (r_pos == POS_HDR) && (r_sum == '0) && r_out_vld)
        else $error("frame end did not restart header search");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |-> !s_emit)
        else $error("result overwritten while stalled");

    a_hdr_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_move && (s_pos == POS_HDR) && (r_in_byte == HDR_BYTE))
            |=> (r_pos == POS_TYPE) && (r_sum == HDR_BYTE))
        else $error("header did not seed running sum");

endmodule

`default_nettype wire
